// ===== hdl/byte_pattern_scanner_assert.svh =====
// Assertion macros for the byte pattern scanner.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef BYTE_PATTERN_SCANNER_ASSERT_SVH
`define BYTE_PATTERN_SCANNER_ASSERT_SVH

// same-cycle implication
`define BPS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bps_pkg.sv =====
// Shared types, constants and helper functions of the byte pattern scanner.
// No dependencies.
`timescale 1ns / 1ps

package bps_pkg;

    localparam int PATTERN_MAX = 8;
    localparam int BANNED_MAX  = 8;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 4;
    localparam int IDX_W       = 3;
    localparam int ADDR_W      = 32;
    localparam int SECT_W      = 8;
    localparam int NUM_W       = 16;
    localparam int WORD_W      = 64;

    // input word layout
    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = 3;
    localparam int IN_SECT_LSB = 0;
    localparam int IN_RVA_LSB  = 8;
    localparam int IN_VAL_LSB  = 40;
    localparam int TU_START    = 0;
    localparam int TU_FIRST    = 1;
    localparam int TU_EXEC     = 2;

    // result word layout
    localparam int M_TDATA_W    = 88;
    localparam int OUT_SECT_LSB = 0;
    localparam int OUT_OFS_LSB  = 8;
    localparam int OUT_RVA_LSB  = 40;
    localparam int OUT_NUM_LSB  = 72;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES  = 3'd0,
        REG_PATTERN_LENGTH = 3'd1,
        REG_BANNED_BYTES   = 3'd2,
        REG_BANNED_COUNT   = 3'd3,
        REG_RESULT_LIMIT   = 3'd4
    } bps_reg_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } bps_cell_ctl_t;

    typedef struct packed {
        logic              start;
        logic              exec;
        logic [SECT_W-1:0] sect;
        logic [ADDR_W-1:0] rva;
        logic [ADDR_W-1:0] seen;
    } bps_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] len;
        logic [NUM_W-1:0] limit;
    } bps_cfg_t;

    typedef struct packed {
        logic             load;
        logic             scan_done;
        logic [NUM_W-1:0] found;
    } bps_status_t;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n, input int max);
        logic [CNT_W-1:0] m;
        m = CNT_W'(max);
        return (n > m) ? m : n;
    endfunction

    // pattern byte that window cell idx must hold: byte len-1-idx of the pattern
    function automatic logic [BYTE_W-1:0] cell_expect(input logic [WORD_W-1:0] pattern,
                                                      input logic [CNT_W-1:0] len,
                                                      input logic [CNT_W-1:0] idx);
        logic [CNT_W-1:0]  k;
        logic [WORD_W-1:0] sh;
        k  = len - idx - CNT_W'(1);
        sh = pattern >> {k[IDX_W-1:0], 3'b000};
        return sh[BYTE_W-1:0];
    endfunction

    function automatic logic [BANNED_MAX-1:0] banned_mask(input logic [CNT_W-1:0] n);
        logic [BANNED_MAX-1:0] m;
        for (int j = 0; j < BANNED_MAX; j++) begin
            m[j] = (CNT_W'(j) < n);
        end
        return m;
    endfunction

endpackage

// ===== hdl/bps_cell.sv =====
// One window cell: holds a byte, passes it on, checks it against its pattern byte
// and the banned set. Depends on bps_pkg.
`timescale 1ns / 1ps

module bps_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bps_pkg::bps_cell_ctl_t              ctl,
    input  logic [bps_pkg::BYTE_W-1:0]          byte_in,
    input  logic [bps_pkg::BYTE_W-1:0]          expect_byte,
    input  logic                                in_use,
    input  logic [bps_pkg::WORD_W-1:0]          banned_bytes,
    input  logic [bps_pkg::BANNED_MAX-1:0]      banned_en,
    output logic [bps_pkg::BYTE_W-1:0]          byte_out,
    output logic                                cell_ok
);
    import bps_pkg::*;

    logic [BYTE_W-1:0]     byte_reg;
    logic [BYTE_W-1:0]     byte_next;
    logic [BANNED_MAX-1:0] ban_hit;

    always_comb begin
        byte_next = byte_reg;
        if (ctl.shift) begin
            byte_next = byte_in;
        end else if (ctl.clear) begin
            byte_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    always_comb begin
        for (int j = 0; j < BANNED_MAX; j++) begin
            ban_hit[j] = banned_en[j] && (byte_reg == banned_bytes[j*BYTE_W +: BYTE_W]);
        end
    end

    assign byte_out = byte_reg;
    assign cell_ok  = !in_use || ((byte_reg == expect_byte) && !(|ban_hit));

endmodule

// ===== hdl/bps_report.sv =====
// Match report stage: found count, scan done flag and the result output register.
// Depends on bps_pkg.
`timescale 1ns / 1ps

module bps_report (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  bps_pkg::bps_item_t                 item,
    input  logic                               window_ok,
    input  bps_pkg::bps_cfg_t                  cfg,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [bps_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast,
    output bps_pkg::bps_status_t               status
);
    import bps_pkg::*;

    logic [NUM_W-1:0]  found_reg, found_next, found_base, found_inc, lim_eff;
    logic              done_reg, done_next, done_base, done_new;
    logic              eligible, hit;
    logic              m_valid_reg, m_valid_next;
    logic [SECT_W-1:0] sect_reg;
    logic [ADDR_W-1:0] ofs_reg, rva_reg;
    logic [NUM_W-1:0]  num_reg;
    logic              last_reg;

    always_comb begin
        found_base = item.start ? '0 : found_reg;
        done_base  = item.start ? 1'b0 : done_reg;
        eligible   = item.exec && (cfg.len != '0) && !done_base
                     && (item.seen >= ADDR_W'(cfg.len));
        hit        = adv && eligible && window_ok;
        found_inc  = found_base + NUM_W'(1);
        lim_eff    = (cfg.limit == '0) ? NUM_W'(1) : cfg.limit;
        done_new   = (found_inc >= lim_eff);

        found_next = found_reg;
        done_next  = done_reg;
        if (adv) begin
            found_next = found_base;
            done_next  = done_base;
        end
        if (hit) begin
            found_next = found_inc;
            done_next  = done_new;
        end

        if (hit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg   <= '0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            found_reg   <= found_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hit) begin
            sect_reg <= item.sect;
            ofs_reg  <= item.seen - ADDR_W'(cfg.len);
            rva_reg  <= item.rva - (ADDR_W'(cfg.len) - ADDR_W'(1));
            num_reg  <= found_inc;
            last_reg <= done_new;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {num_reg, rva_reg, ofs_reg, sect_reg};
    assign m_tlast  = last_reg;

    assign status.load      = hit;
    assign status.scan_done = done_reg;
    assign status.found     = found_reg;

endmodule

// ===== hdl/byte_pattern_scanner.sv =====
// Byte pattern scanner top level: configuration registers, input stage and the
// row of window cells. Depends on bps_pkg, bps_cell, bps_report and the assert header.
`timescale 1ns / 1ps

// Usage:
//   s_ channel carries one image byte per word: tdata holds section index, RVA and
//   byte value; tuser holds scan start, section first and executable flags.
//   m_ channel carries one word per reported match: section, offset in section,
//   start RVA and match number in tdata; tlast is high on the last match of a scan.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data while idle.
// Timing:
//   An accepted executable byte shifts into an 8-cell window row in the same edge, and
//   its item is registered in the input stage; the cells compare in parallel and, once
//   the output register is free, a match's report lands there and raises m_tvalid.
//   One byte per cycle is taken while the output register is free or drained.
// Stall: when m_tready is low and a result is held, one more byte waits in the
//   window stage, then s_tready drops until the result is taken.
// Reset: window, offset counter, found count and scan-done flag clear; the pattern
//   length resets to 0 (no matches) and the result limit to 1.
module byte_pattern_scanner (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // {byte_value, byte_rva, section_index}
    input  logic [bps_pkg::S_TDATA_W-1:0]       s_tdata,
    // {section_exec, section_first, scan_start}
    input  logic [bps_pkg::S_TUSER_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // {match_number, match_rva, match_offset, match_section}
    output logic [bps_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bps_pkg::WORD_W-1:0]          cfg_data
);
    import bps_pkg::*;

    `include "byte_pattern_scanner_assert.svh"

    // configuration
    logic [WORD_W-1:0] pattern_reg, banned_reg;
    logic [CNT_W-1:0]  plen_reg, bcount_reg;
    logic [NUM_W-1:0]  limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            plen_reg    <= '0;
            banned_reg  <= '0;
            bcount_reg  <= '0;
            limit_reg   <= NUM_W'(1);
        end else if (cfg_we) begin
            case (bps_reg_t'(cfg_index))
                REG_PATTERN_BYTES:  pattern_reg <= cfg_data;
                REG_PATTERN_LENGTH: plen_reg    <= cfg_data[CNT_W-1:0];
                REG_BANNED_BYTES:   banned_reg  <= cfg_data;
                REG_BANNED_COUNT:   bcount_reg  <= cfg_data[CNT_W-1:0];
                REG_RESULT_LIMIT:   limit_reg   <= cfg_data[NUM_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0]      len_eff;
    logic [BANNED_MAX-1:0] ban_en;
    bps_cfg_t              cfg;

    assign len_eff   = clamp_count(plen_reg, PATTERN_MAX);
    assign ban_en    = banned_mask(clamp_count(bcount_reg, BANNED_MAX));
    assign cfg.len   = len_eff;
    assign cfg.limit = limit_reg;

    // input stage
    logic              s_accept, in_start, in_first, in_exec, restart;
    logic              p1_valid_reg, p1_valid_next, out_free, p1_adv;
    logic [ADDR_W-1:0] seen_reg, seen_next, seen_base;
    bps_item_t         p1_item_reg;
    bps_cell_ctl_t     cell_ctl;
    bps_status_t       status;

    assign in_start = s_tuser[TU_START];
    assign in_first = s_tuser[TU_FIRST];
    assign in_exec  = s_tuser[TU_EXEC];
    assign restart  = in_start || in_first;

    assign out_free = !m_tvalid || m_tready;
    assign p1_adv   = p1_valid_reg && out_free;
    assign s_tready = !p1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    assign cell_ctl.shift = s_accept && in_exec;
    assign cell_ctl.clear = s_accept && restart;

    always_comb begin
        seen_base = restart ? '0 : seen_reg;
        seen_next = seen_reg;
        if (s_accept) begin
            if (in_exec && (seen_base != '1)) begin
                seen_next = seen_base + ADDR_W'(1);
            end else begin
                seen_next = seen_base;
            end
        end

        if (s_accept) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end else begin
            p1_valid_next = p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            seen_reg     <= seen_next;
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_item_reg.start <= in_start;
            p1_item_reg.exec  <= in_exec;
            p1_item_reg.sect  <= s_tdata[IN_SECT_LSB +: SECT_W];
            p1_item_reg.rva   <= s_tdata[IN_RVA_LSB +: ADDR_W];
            p1_item_reg.seen  <= seen_next;
        end
    end

    // window cell row, newest byte in cell 0
    logic [BYTE_W-1:0]      cell_byte [PATTERN_MAX];
    logic [BYTE_W-1:0]      cell_in   [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_ok;

    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign cell_in[i] = s_tdata[IN_VAL_LSB +: BYTE_W];
        end else begin : g_tail
            // on a restart the older bytes drop out
            assign cell_in[i] = restart ? '0 : cell_byte[i-1];
        end

        bps_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctl          (cell_ctl),
            .byte_in      (cell_in[i]),
            .expect_byte  (cell_expect(pattern_reg, len_eff, CNT_W'(i))),
            .in_use       (CNT_W'(i) < len_eff),
            .banned_bytes (banned_reg),
            .banned_en    (ban_en),
            .byte_out     (cell_byte[i]),
            .cell_ok      (cell_ok[i])
        );
    end

    bps_report u_report (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (p1_adv),
        .item      (p1_item_reg),
        .window_ok (&cell_ok),
        .cfg       (cfg),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .status    (status)
    );

    // checks
    `BPS_ASSERT_NOW(a_no_report_after_limit, p1_adv && status.scan_done && !p1_item_reg.start, !status.load, "match reported after scan limit")
    `BPS_ASSERT_NEXT(a_report_number, status.load, m_tvalid && (m_tdata[OUT_NUM_LSB +: NUM_W] == status.found), "reported match number differs from found count")
    `BPS_ASSERT_NEXT(a_restart_offset, s_accept && restart, seen_reg == ADDR_W'($past(in_exec)), "section offset not restarted")

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for byte_pattern_scanner: streams image bytes, predicts matches
// and compares every result word field by field. Depends on bps_pkg and the scanner RTL.
`timescale 1ns / 1ps

module testbench;
    import bps_pkg::*;

    typedef struct packed {
        logic              start;
        logic              first;
        logic              exec;
        logic [SECT_W-1:0] sect;
        logic [ADDR_W-1:0] rva;
        logic [BYTE_W-1:0] val;
    } scan_byte_t;

    typedef struct packed {
        logic [SECT_W-1:0] sect;
        logic [ADDR_W-1:0] ofs;
        logic [ADDR_W-1:0] rva;
        logic [NUM_W-1:0]  num;
        logic              last;
    } match_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // {byte_value, byte_rva, section_index}
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    // {section_exec, section_first, scan_start}
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // {match_number, match_rva, match_offset, match_section}
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_PATTERN_BYTES;
    logic [WORD_W-1:0]     cfg_data  = '0;

    byte_pattern_scanner DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // shadow registers and scanner state
    logic [WORD_W-1:0] pat_word  = '0;
    logic [CNT_W-1:0]  pat_len   = '0;
    logic [WORD_W-1:0] ban_word  = '0;
    logic [CNT_W-1:0]  ban_cnt   = '0;
    logic [NUM_W-1:0]  res_limit = 16'd1;
    logic [BYTE_W-1:0] win [PATTERN_MAX] = '{default: '0};
    logic [ADDR_W-1:0] seen_cnt  = '0;
    logic [NUM_W-1:0]  found_cnt = '0;
    bit                scan_over = 1'b0;

    scan_byte_t byte_feed[$];
    match_t     match_queue[$];
    int         exec_fed    = 0;
    int         error_count = 0;
    int         send_idle   = 25;
    int         recv_idle   = 71;
    bit         word_taken  = 1'b0;
    logic [BYTE_W-1:0] sym_a, sym_b;
    logic [SECT_W-1:0] cur_sect = '0;
    logic [ADDR_W-1:0] cur_rva  = '0;

    function automatic bit predict_match(input scan_byte_t b, output match_t m);
        int  len;
        int  nb;
        bit  hit;
        logic [ADDR_W-1:0] lim;
        m = '0;
        if (b.start) begin
            found_cnt = '0;
            scan_over = 1'b0;
        end
        if (b.start || b.first) begin
            win      = '{default: '0};
            seen_cnt = '0;
        end
        if (!b.exec)
            return 1'b0;
        for (int i = PATTERN_MAX - 1; i > 0; i--)
            win[i] = win[i-1];
        win[0] = b.val;
        if (seen_cnt != '1)
            seen_cnt++;
        len = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
        nb  = (ban_cnt > BANNED_MAX) ? BANNED_MAX : ban_cnt;
        if (len == 0 || scan_over || seen_cnt < ADDR_W'(len))
            return 1'b0;
        hit = 1'b1;
        // oldest window byte lines up with pattern byte 0
        for (int i = 0; i < len; i++)
            if (win[len-1-i] != pat_word[8*i +: 8])
                hit = 1'b0;
        for (int j = 0; j < nb; j++)
            for (int i = 0; i < len; i++)
                if (win[i] == ban_word[8*j +: 8])
                    hit = 1'b0;
        if (!hit)
            return 1'b0;
        found_cnt++;
        lim = (res_limit == '0) ? ADDR_W'(1) : ADDR_W'(res_limit);
        if (ADDR_W'(found_cnt) >= lim)
            scan_over = 1'b1;
        m.sect = b.sect;
        m.ofs  = seen_cnt - ADDR_W'(len);
        m.rva  = b.rva - ADDR_W'(len - 1);
        m.num  = found_cnt;
        m.last = scan_over;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic void queue_byte(input bit start, input bit first, input bit exec,
                                       input logic [SECT_W-1:0] sect,
                                       input logic [ADDR_W-1:0] rva,
                                       input logic [BYTE_W-1:0] val);
        scan_byte_t entry;
        entry     = '{start, first, exec, sect, rva, val};
        byte_feed = {byte_feed, entry};
        if (exec)
            exec_fed++;
    endfunction

    // driver: next word goes out on the falling edge
    always @(negedge aclk) begin : feed_driver
        scan_byte_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle) begin
                nxt = byte_feed.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {nxt.val, nxt.rva, nxt.sect};
                s_tuser  <= {nxt.exec, nxt.first, nxt.start};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // monitor: predict on input accept, then check any result word
    always @(posedge aclk) begin : result_monitor
        scan_byte_t b;
        match_t     want;
        match_t     got;
        word_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                b.start = s_tuser[TU_START];
                b.first = s_tuser[TU_FIRST];
                b.exec  = s_tuser[TU_EXEC];
                b.sect  = s_tdata[IN_SECT_LSB +: SECT_W];
                b.rva   = s_tdata[IN_RVA_LSB +: ADDR_W];
                b.val   = s_tdata[IN_VAL_LSB +: BYTE_W];
                if (predict_match(b, want))
                    match_queue = {match_queue, want};
            end
            if (m_tvalid && m_tready) begin
                got.sect = m_tdata[OUT_SECT_LSB +: SECT_W];
                got.ofs  = m_tdata[OUT_OFS_LSB +: ADDR_W];
                got.rva  = m_tdata[OUT_RVA_LSB +: ADDR_W];
                got.num  = m_tdata[OUT_NUM_LSB +: NUM_W];
                got.last = m_tlast;
                if (match_queue.size() == 0) begin
                    report_mismatch("match with none pending", m_tdata[63:0], 0);
                end else begin
                    want = match_queue.pop_front();
                    if (got.sect != want.sect) report_mismatch("section", got.sect, want.sect);
                    if (got.ofs != want.ofs)   report_mismatch("offset", got.ofs, want.ofs);
                    if (got.rva != want.rva)   report_mismatch("rva", got.rva, want.rva);
                    if (got.num != want.num)   report_mismatch("number", got.num, want.num);
                    if (got.last != want.last) report_mismatch("tlast", got.last, want.last);
                end
            end
        end
    end

    task automatic write_reg(input bps_reg_t idx, input logic [WORD_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_PATTERN_BYTES:  pat_word  = value;
            REG_PATTERN_LENGTH: pat_len   = value[CNT_W-1:0];
            REG_BANNED_BYTES:   ban_word  = value;
            REG_BANNED_COUNT:   ban_cnt   = value[CNT_W-1:0];
            REG_RESULT_LIMIT:   res_limit = value[NUM_W-1:0];
            default: ;
        endcase
    endtask

    // holds the sequence until every byte is sent and every result is back, then lets the pipe drain
    task automatic wait_idle();
        do @(posedge aclk);
        while (byte_feed.size() != 0 || s_tvalid || match_queue.size() != 0);
        repeat (6) @(negedge aclk);
    endtask

    task automatic pick_setup();
        logic [WORD_W-1:0] pw;
        logic [WORD_W-1:0] bw;
        sym_a = 8'($urandom);
        sym_b = 8'($urandom);
        for (int i = 0; i < PATTERN_MAX; i++)
            pw[8*i +: 8] = ($urandom_range(9) == 0) ? 8'($urandom) :
                           ($urandom_range(1) ? sym_a : sym_b);
        bw = {$urandom, $urandom};
        if ($urandom_range(4) == 0)
            bw[7:0] = sym_b;
        write_reg(REG_PATTERN_BYTES, pw);
        case ($urandom_range(9))
            0:       write_reg(REG_PATTERN_LENGTH, 0);
            1:       write_reg(REG_PATTERN_LENGTH, $urandom_range(15, 9));
            2, 3, 4: write_reg(REG_PATTERN_LENGTH, $urandom_range(1, 2));
            default: write_reg(REG_PATTERN_LENGTH, $urandom_range(1, 8));
        endcase
        write_reg(REG_BANNED_BYTES, bw);
        write_reg(REG_BANNED_COUNT, $urandom_range(15));
        case ($urandom_range(5))
            0:       write_reg(REG_RESULT_LIMIT, 0);
            1:       write_reg(REG_RESULT_LIMIT, 1);
            2:       write_reg(REG_RESULT_LIMIT, 16'hFFFF);
            3:       write_reg(REG_RESULT_LIMIT, $urandom_range(65535));
            default: write_reg(REG_RESULT_LIMIT, $urandom_range(2, 12));
        endcase
    endtask

    // mostly pattern bursts and bytes from a two-symbol alphabet, some noise
    task automatic fill_random(input int n_exec);
        int  goal;
        int  len;
        bit  st;
        bit  fs;
        logic [BYTE_W-1:0] v;
        goal = exec_fed + n_exec;
        len  = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
        while (exec_fed < goal) begin
            st = ($urandom_range(39) == 0);
            fs = ($urandom_range(29) == 0);
            if (fs)
                cur_sect = 8'($urandom);
            if ($urandom_range(19) == 0)
                cur_rva = $urandom;
            if ($urandom_range(3) == 0 && len != 0) begin
                for (int k = 0; k < len; k++) begin
                    queue_byte(k == 0 && st, k == 0 && fs, 1'b1, cur_sect, cur_rva,
                               pat_word[8*k +: 8]);
                    cur_rva++;
                end
            end else begin
                v = ($urandom_range(5) == 0) ? 8'($urandom) :
                    ($urandom_range(1) ? sym_a : sym_b);
                queue_byte(st, fs, $urandom_range(9) != 0, cur_sect, cur_rva, v);
                cur_rva++;
            end
        end
    endtask

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // pattern FF 00 FF, limit 3: wrapping rva, skipped byte, rva jump, new section,
        // limit hit and a fresh scan
        write_reg(REG_PATTERN_BYTES, 64'h0000_0000_00FF_00FF);
        write_reg(REG_PATTERN_LENGTH, 3);
        write_reg(REG_BANNED_BYTES, 64'h7E);
        write_reg(REG_BANNED_COUNT, 1);
        write_reg(REG_RESULT_LIMIT, 3);
        queue_byte(1, 1, 1, 8'hFF, 32'hFFFF_FFFE, 8'hFF);
        queue_byte(0, 0, 1, 8'hFF, 32'hFFFF_FFFF, 8'h00);
        queue_byte(0, 0, 1, 8'hFF, 32'h0000_0000, 8'hFF);
        queue_byte(0, 0, 0, 8'hFF, 32'h0000_0001, 8'h00);
        queue_byte(0, 0, 1, 8'hFF, 32'h0000_0010, 8'h00);
        queue_byte(0, 0, 1, 8'hFF, 32'h0000_0020, 8'hFF);
        queue_byte(0, 0, 1, 8'hFF, 32'h0000_0021, 8'h7E);
        queue_byte(0, 0, 1, 8'hFF, 32'h0000_0022, 8'hFF);
        queue_byte(0, 1, 1, 8'h00, 32'h0000_0100, 8'hFF);
        queue_byte(0, 0, 1, 8'h00, 32'h0000_0101, 8'h00);
        queue_byte(0, 0, 1, 8'h00, 32'h0000_0102, 8'hFF);
        queue_byte(0, 0, 1, 8'h00, 32'h0000_0103, 8'h00);
        queue_byte(0, 0, 1, 8'h00, 32'h0000_0104, 8'hFF);
        queue_byte(1, 0, 1, 8'h00, 32'h0000_0105, 8'hFF);
        queue_byte(0, 0, 1, 8'h00, 32'h0000_0106, 8'h00);
        queue_byte(0, 0, 1, 8'h00, 32'h0000_0107, 8'hFF);
        wait_idle();

        // oversized length and banned count; pattern holds a banned byte, so dropped
        write_reg(REG_PATTERN_BYTES, 64'h8877_6655_4433_2211);
        write_reg(REG_PATTERN_LENGTH, 15);
        write_reg(REG_BANNED_BYTES, 64'h4400_0000_0000_0000);
        write_reg(REG_BANNED_COUNT, 15);
        write_reg(REG_RESULT_LIMIT, 0);
        for (int k = 0; k < PATTERN_MAX; k++)
            queue_byte(k == 0, k == 0, 1, 8'h80, 32'h7FFF_FFF8 + k, 8'(8'h11 * (k + 1)));
        wait_idle();

        // empty pattern: nothing reported
        write_reg(REG_BANNED_COUNT, 7);
        write_reg(REG_PATTERN_LENGTH, 0);
        queue_byte(1, 1, 1, 8'h01, 32'h1000, 8'h11);
        wait_idle();

        // full length again; limit of zero acts as one
        write_reg(REG_PATTERN_LENGTH, 8);
        for (int k = 1; k < PATTERN_MAX; k++)
            queue_byte(0, 0, 1, 8'h01, 32'h1000 + k, 8'(8'h11 * (k + 1)));
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            case ((p * 3) / 8)
                0: begin send_idle = 25; recv_idle = 71; end
                1: begin send_idle = 71; recv_idle = 25; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            pick_setup();
            fill_random(70);
            wait_idle();
        end

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== byte_pattern_scanner.f =====
+incdir+hdl
hdl/bps_pkg.sv
hdl/bps_cell.sv
hdl/bps_report.sv
hdl/byte_pattern_scanner.sv
bench/testbench.sv
